// ===== hw/rtl/rsl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsl_pkg: shared types and constants for the record sort and lookup block
// record layout, opcodes and table sizes
// ----------------------------------------------------------------------------
package rsl_pkg;

    localparam int MaxRecords = 1024;
    localparam int IdxW       = $clog2(MaxRecords);
    localparam int CntW       = IdxW + 1;
    localparam int RecW       = 64 + 16 + 64 + 56 + 32;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_READ  = 2'd1,
        OP_FIND_SUR = 2'd2,
        OP_FIND_FIRST = 2'd3
    } op_t;

    typedef struct packed {
        logic [63:0] surname_high;
        logic [55:0] surname_low;
        logic [63:0] first_high;
        logic [15:0] first_low;
        logic [31:0] salary;
    } rec_t;

    // true when key of a is strictly greater than key of b
    function automatic logic key_gt(input rec_t a, input rec_t b);
        logic [199:0] ka;
        logic [199:0] kb;
        ka = {a.surname_high, a.surname_low, a.first_high, a.first_low};
        kb = {b.surname_high, b.surname_low, b.first_high, b.first_low};
        return ka > kb;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/record_sort_and_lookup_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// record_sort_and_lookup_top: record table with stable sort and lookups
// loads records into one memory, sorts on the last load, answers queries
// ----------------------------------------------------------------------------
// load: one request per cycle while no reply is pending; a last load adds a
//   stable insertion sort, quadratic in the record count
// read by index: registered through read data and ST_QWAIT (same edge when
//   out of range); next request taken in the cycle after the result leaves
// find: walks entries from index 0 to the first match over the one read port
// reset: async active low clears count, flags and control; table undefined
// ----------------------------------------------------------------------------
module record_sort_and_lookup_top (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    // op[1:0], first_high[65:2], first_low[81:66], surname_high[145:82],
    // surname_low[201:146], salary[233:202], index[243:234], zero pad
    input  wire [247:0] s_tdata,
    input  wire         s_tlast,
    output logic        m_tvalid,
    input  wire         m_tready,
    // status[0], out_first_high[64:1], out_first_low[80:65],
    // out_surname_high[144:81], out_surname_low[200:145], out_salary[232:201],
    // overflowed[233], zero pad
    output logic [239:0] m_tdata
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_SREAD  = 8'b0000_0010,  // read key record i
        ST_SCMP   = 8'b0000_0100,  // read j-1
        ST_SEVAL  = 8'b0000_1000,  // compare and shift
        ST_QWAIT  = 8'b0001_0000,  // data for query read
        ST_FIND   = 8'b0010_0000,  // walk entries
        ST_OUT    = 8'b0100_0000,
        ST_KWAIT  = 8'b1000_0000   // key record data arriving
    } state_t;

    // table memory, one read and one write port
    rsl_pkg::rec_t mem [rsl_pkg::MaxRecords];
    rsl_pkg::rec_t rd_data_reg;
    logic [rsl_pkg::IdxW-1:0] rd_addr;
    logic                     wr_en;
    logic [rsl_pkg::IdxW-1:0] wr_addr;
    rsl_pkg::rec_t            wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    state_t state_reg, state_next;
    logic [rsl_pkg::CntW-1:0] count_reg, count_next;
    logic closed_reg, closed_next;
    logic ovf_reg, ovf_next;
    logic [rsl_pkg::CntW-1:0] i_reg, i_next;   // sort outer / find cursor
    logic [rsl_pkg::IdxW-1:0] j_reg, j_next;
    rsl_pkg::rec_t key_reg, key_next;
    logic [1:0] op_reg, op_next;
    logic [199:0] qkey_reg, qkey_next;   // search key request fields
    logic m_valid_reg, m_valid_next;
    logic [239:0] m_data_reg, m_data_next;

    rsl_pkg::rec_t in_rec;
    logic [1:0]  in_op;
    logic [rsl_pkg::IdxW-1:0] in_idx;
    assign in_op = s_tdata[1:0];
    assign in_rec.first_high   = s_tdata[65:2];
    assign in_rec.first_low    = s_tdata[81:66];
    assign in_rec.surname_high = s_tdata[145:82];
    assign in_rec.surname_low  = s_tdata[201:146];
    assign in_rec.salary       = s_tdata[233:202];
    assign in_idx = s_tdata[243:234];

    assign s_tready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    function automatic logic [239:0] pack_out(input logic found, input rsl_pkg::rec_t r,
                                              input logic ovf);
        logic [239:0] d;
        d = '0;
        d[0] = !found;
        if (found)
        begin
            d[64:1]    = r.first_high;
            d[80:65]   = r.first_low;
            d[144:81]  = r.surname_high;
            d[200:145] = r.surname_low;
            d[232:201] = r.salary;
        end
        d[233] = ovf;
        return d;
    endfunction

    logic match;
    always_comb
    begin
        if (op_reg == rsl_pkg::OP_FIND_SUR)
        begin
            match = {rd_data_reg.surname_high, rd_data_reg.surname_low} == qkey_reg[199:80];
        end
        else
        begin
            match = {rd_data_reg.first_high, rd_data_reg.first_low} == qkey_reg[79:0];
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        closed_next  = closed_reg;
        ovf_next     = ovf_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        key_next     = key_reg;
        op_next      = op_reg;
        qkey_next    = qkey_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        rd_addr      = i_reg[rsl_pkg::IdxW-1:0];
        wr_en        = 1'b0;
        wr_addr      = j_reg;
        wr_data      = key_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    op_next   = in_op;
                    qkey_next = {in_rec.surname_high, in_rec.surname_low,
                                 in_rec.first_high, in_rec.first_low};
                    if (in_op == rsl_pkg::OP_LOAD)
                    begin
                        logic [rsl_pkg::CntW-1:0] c;
                        logic                     o;
                        c = closed_reg ? '0 : count_reg;
                        o = closed_reg ? 1'b0 : ovf_reg;
                        closed_next = 1'b0;
                        if (c < rsl_pkg::CntW'(rsl_pkg::MaxRecords))
                        begin
                            wr_en   = 1'b1;
                            wr_addr = c[rsl_pkg::IdxW-1:0];
                            wr_data = in_rec;
                            c = c + 1'b1;
                        end
                        else
                        begin
                            o = 1'b1;
                        end
                        count_next = c;
                        ovf_next   = o;
                        if (s_tlast)
                        begin
                            closed_next = 1'b1;
                            i_next      = rsl_pkg::CntW'(1);
                            state_next  = ST_SREAD;
                        end
                    end
                    else if (in_op == rsl_pkg::OP_READ)
                    begin
                        rd_addr = in_idx;
                        if ({1'b0, in_idx} < count_reg)
                        begin
                            state_next = ST_QWAIT;
                        end
                        else
                        begin
                            m_data_next  = pack_out(1'b0, key_reg, ovf_reg);
                            m_valid_next = 1'b1;
                        end
                    end
                    else
                    begin
                        // no entry under compare yet
                        i_next     = '0;
                        j_next     = '0;
                        state_next = ST_FIND;
                    end
                end
            end
            ST_SREAD:
            begin
                if (i_reg >= count_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    rd_addr    = i_reg[rsl_pkg::IdxW-1:0];
                    j_next     = i_reg[rsl_pkg::IdxW-1:0];
                    state_next = ST_KWAIT;
                end
            end
            ST_KWAIT:
            begin
                key_next   = rd_data_reg;
                rd_addr    = j_reg - 1'b1;
                state_next = ST_SEVAL;
            end
            ST_SCMP:
            begin
                rd_addr    = j_reg - 1'b1;
                state_next = ST_SEVAL;
            end
            ST_SEVAL:
            begin
                if (rsl_pkg::key_gt(rd_data_reg, key_reg))
                begin
                    wr_en   = 1'b1;
                    wr_addr = j_reg;
                    wr_data = rd_data_reg;
                    j_next  = j_reg - 1'b1;
                    if (j_reg == rsl_pkg::IdxW'(1))
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_SCMP;
                    end
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // final placement of the key, then next outer step
                wr_en      = 1'b1;
                wr_addr    = j_reg;
                wr_data    = key_reg;
                i_next     = i_reg + 1'b1;
                state_next = ST_SREAD;
            end
            ST_QWAIT:
            begin
                m_data_next  = pack_out(1'b1, rd_data_reg, ovf_reg);
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_FIND:
            begin
                // i_reg: entry under compare is i_reg-1 when j_reg flag set
                if (j_reg[0] && match)
                begin
                    m_data_next  = pack_out(1'b1, rd_data_reg, ovf_reg);
                    m_valid_next = 1'b1;
                    j_next       = '0;
                    state_next   = ST_IDLE;
                end
                else if (i_reg >= count_reg)
                begin
                    m_data_next  = pack_out(1'b0, rd_data_reg, ovf_reg);
                    m_valid_next = 1'b1;
                    j_next       = '0;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    rd_addr = i_reg[rsl_pkg::IdxW-1:0];
                    i_next  = i_reg + 1'b1;
                    j_next  = rsl_pkg::IdxW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            closed_reg  <= 1'b0;
            ovf_reg     <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            closed_reg  <= closed_next;
            ovf_reg     <= ovf_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        op_reg     <= op_next;
        qkey_reg   <= qkey_next;
        m_data_reg <= m_data_next;
    end

endmodule
`default_nettype wire

// ===== tb/record_sort_and_lookup_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_sort_and_lookup_top_tb: self-checking bench for the record table
// streams record loads and lookups and keeps a table model beside the design;
// each reply is compared field by field in request order
// ----------------------------------------------------------------------------
module record_sort_and_lookup_top_tb;
    import rsl_pkg::*;

    localparam int QuietLimit = 40000;

    typedef struct {
        logic [63:0] sh;
        logic [55:0] sl;
        logic [63:0] fh;
        logic [15:0] fl;
        logic [31:0] sal;
    } person_t;

    typedef struct {
        logic        status;
        logic [63:0] fh;
        logic [15:0] fl;
        logic [63:0] sh;
        logic [55:0] sl;
        logic [31:0] sal;
        logic        ovf;
    } reply_t;

    // table model plus the replies still owed by the design
    class staff_table_model;
        person_t staff [MaxRecords];
        int      count;
        bit      closed;
        bit      ovf;
        reply_t  owed_replies [$];
        int      errors;

        function bit later_key(person_t a, person_t b);
            if (a.sh != b.sh) return a.sh > b.sh;
            if (a.sl != b.sl) return a.sl > b.sl;
            if (a.fh != b.fh) return a.fh > b.fh;
            return a.fl > b.fl;
        endfunction

        // stable insertion sort of the loaded entries
        function void sort_staff();
            person_t cur;
            int j;
            for (int i = 1; i < count; i++)
            begin
                cur = staff[i];
                j = i;
                while (j > 0 && later_key(staff[j-1], cur))
                begin
                    staff[j] = staff[j-1];
                    j--;
                end
                staff[j] = cur;
            end
        endfunction

        function void note_request(logic [247:0] d, logic lst);
            op_t     op;
            person_t p;
            logic [9:0] idx;
            reply_t  r;
            int      hit;
            op    = op_t'(d[1:0]);
            p.fh  = d[65:2];
            p.fl  = d[81:66];
            p.sh  = d[145:82];
            p.sl  = d[201:146];
            p.sal = d[233:202];
            idx   = d[243:234];
            if (op == OP_LOAD)
            begin
                if (closed)
                begin
                    count = 0;
                    ovf = 0;
                    closed = 0;
                end
                if (count < MaxRecords)
                begin
                    staff[count] = p;
                    count++;
                end
                else
                    ovf = 1;
                if (lst)
                begin
                    sort_staff();
                    closed = 1;
                end
                return;
            end
            hit = -1;
            if (op == OP_READ)
            begin
                if (idx < count) hit = idx;
            end
            else
            begin
                for (int i = 0; i < count && hit < 0; i++)
                    if (op == OP_FIND_SUR ? (staff[i].sh == p.sh && staff[i].sl == p.sl)
                                          : (staff[i].fh == p.fh && staff[i].fl == p.fl))
                        hit = i;
            end
            r = '{1'b1, '0, '0, '0, '0, '0, ovf};
            if (hit >= 0)
                r = '{1'b0, staff[hit].fh, staff[hit].fl, staff[hit].sh,
                      staff[hit].sl, staff[hit].sal, ovf};
            owed_replies.push_back(r);
        endfunction

        function void check_reply(logic [239:0] d);
            reply_t e;
            if (owed_replies.size() == 0)
            begin
                $error("reply with none owed: %h", d);
                errors++;
                return;
            end
            e = owed_replies.pop_front();
            if (d[0] !== e.status)
            begin
                $error("status exp %h got %h", e.status, d[0]); errors++;
            end
            if (d[64:1] !== e.fh)
            begin
                $error("out_first_high exp %h got %h", e.fh, d[64:1]); errors++;
            end
            if (d[80:65] !== e.fl)
            begin
                $error("out_first_low exp %h got %h", e.fl, d[80:65]); errors++;
            end
            if (d[144:81] !== e.sh)
            begin
                $error("out_surname_high exp %h got %h", e.sh, d[144:81]); errors++;
            end
            if (d[200:145] !== e.sl)
            begin
                $error("out_surname_low exp %h got %h", e.sl, d[200:145]); errors++;
            end
            if (d[232:201] !== e.sal)
            begin
                $error("out_salary exp %0d got %0d", $signed(e.sal), $signed(d[232:201]));
                errors++;
            end
            if (d[233] !== e.ovf)
            begin
                $error("overflowed exp %h got %h", e.ovf, d[233]); errors++;
            end
        endfunction
    endclass

    logic         clk = 0;
    logic         rst_n = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [247:0] s_tdata = '0;
    logic         s_tlast = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [239:0] m_tdata;

    staff_table_model model = new();
    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    bit  s_fire = 0;
    int  quiet_cycles = 0;
    person_t name_pool [8];
    int  set_size;

    record_sort_and_lookup_top uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    // both handshakes are taken from pre-edge values at the rising edge
    always @(posedge clk)
    begin
        s_fire <= s_tvalid && s_tready;
        if (s_tvalid && s_tready)
            model.note_request(s_tdata, s_tlast);
        if (m_tvalid && m_tready)
            model.check_reply(m_tdata);
    end

    // receiver back-pressure
    always @(negedge clk)
        if (rst_n)
            m_tready <= ($urandom_range(99) >= rx_idle_pct);

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > QuietLimit)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // one request; random sender gap first, then hold until taken
    task automatic send_request(op_t op, person_t p, logic lst, logic [9:0] idx);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 0;
            @(negedge clk);
        end
        s_tdata  <= {4'b0, idx, p.sal, p.sl, p.sh, p.fl, p.fh, op};
        s_tlast  <= lst;
        s_tvalid <= 1;
        do @(negedge clk); while (!s_fire);
    endtask

    // hold off until every owed reply has come back
    task automatic drain();
        s_tvalid <= 0;
        while (model.owed_replies.size() != 0)
            @(negedge clk);
    endtask

    function automatic person_t random_person();
        person_t p;
        p = name_pool[$urandom_range(7)];
        if ($urandom_range(9) == 0)
        begin
            p.fh = rand64(); p.fl = 16'($urandom);
        end
        if ($urandom_range(9) == 0)
        begin
            p.sh = rand64(); p.sl = 56'(rand64());
        end
        if ($urandom_range(3) == 0) p.fh = name_pool[$urandom_range(7)].fh;
        p.sal = $urandom;
        return p;
    endfunction

    // one query of random kind, mostly aimed at live entries and pool names
    task automatic random_query();
        op_t op;
        logic [9:0] idx;
        op = op_t'($urandom_range(3, 1));
        idx = ($urandom_range(7) == 0) ? 10'($urandom) : 10'($urandom_range(model.count + 1));
        send_request(op, random_person(), $urandom_range(1), idx);
    endtask

    task automatic random_set();
        set_size = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
        for (int i = 0; i < set_size; i++)
        begin
            send_request(OP_LOAD, random_person(), i == set_size - 1, 10'($urandom));
            if ($urandom_range(5) == 0) random_query();
        end
        repeat ($urandom_range(6)) random_query();
    endtask

    initial
    begin
        person_t p;
        for (int i = 0; i < 8; i++)
        begin
            name_pool[i].sh  = {8'h41 + 8'(i % 3), 8'h62, 48'h0};
            name_pool[i].sl  = '0;
            name_pool[i].fh  = {8'h4a, 8'h61 + 8'(i / 3), 48'h0};
            name_pool[i].fl  = '0;
            name_pool[i].sal = 0;
        end
        repeat (5) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: queries on an empty table
        tx_idle_pct = 0; rx_idle_pct = 0;
        p = '{'0, '0, '0, '0, '0};
        send_request(OP_READ, p, 0, 10'd0);
        send_request(OP_FIND_SUR, p, 0, 10'd0);
        send_request(OP_FIND_FIRST, p, 0, 10'd1023);
        // extremes, equal keys kept in load order, bytes after a nul
        p = '{'1, '1, '1, '1, 32'h7fffffff};
        send_request(OP_LOAD, p, 0, 10'd1023);
        p = '{64'h4200_0000_0000_0000, '0, 64'h4100_0000_0000_0000, '0, 32'h80000000};
        send_request(OP_LOAD, p, 0, 10'd0);
        p.sal = 32'd5;
        send_request(OP_LOAD, p, 0, 10'd0);
        p = '{64'h4200_0000_0000_0000, '0, 64'h4100_0000_0000_0001, '0, 32'd7};
        send_request(OP_LOAD, p, 0, 10'd0);
        // query before the set is closed sees load order
        send_request(OP_READ, p, 0, 10'd0);
        p = '{'0, '0, '0, '0, 32'hffffffff};
        send_request(OP_LOAD, p, 1, 10'd0);
        for (int i = 0; i < 6; i++)
            send_request(OP_READ, p, 0, 10'(i));
        p = '{64'h4200_0000_0000_0000, '0, 64'h4100_0000_0000_0001, '0, 32'd0};
        send_request(OP_FIND_SUR, p, 0, 10'd0);
        send_request(OP_FIND_FIRST, p, 0, 10'd0);
        p.fh = 64'h4100_0000_0000_0002;
        send_request(OP_FIND_FIRST, p, 0, 10'd0);
        // load after a closed set starts a fresh table
        p = '{rand64(), 56'(rand64()), rand64(), 16'($urandom), 32'd1};
        send_request(OP_LOAD, p, 1, 10'd0);
        send_request(OP_READ, p, 0, 10'd1);
        drain();

        // random sets under three back-pressure mixes
        for (int ph = 0; ph < 3; ph++)
        begin
            tx_idle_pct = (ph == 0) ? 13 : (ph == 1) ? 71 : 0;
            rx_idle_pct = (ph == 0) ? 71 : (ph == 1) ? 13 : 0;
            for (int n = 0; n < 2; n++)
            begin
                random_set();
                if (n == 0) drain();
            end
            drain();
        end

        // full table: ascending keys keep the sort short, the extra load drops
        for (int i = 0; i <= MaxRecords; i++)
        begin
            p = '{64'(i), '0, '0, '0, 32'(i)};
            send_request(OP_LOAD, p, i == MaxRecords, 10'd0);
        end
        p = '{64'(MaxRecords - 1), '0, '0, '0, '0};
        send_request(OP_READ, p, 0, 10'(MaxRecords - 1));
        send_request(OP_FIND_SUR, p, 0, 10'd0);
        p.sh = 64'(MaxRecords);
        send_request(OP_FIND_SUR, p, 0, 10'd0);
        drain();

        repeat (200) @(negedge clk);
        if (model.errors == 0 && model.owed_replies.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// ===== record_sort_and_lookup_top.f =====
hw/rtl/rsl_pkg.sv
hw/rtl/record_sort_and_lookup_top.sv
tb/record_sort_and_lookup_top_tb.sv
